>>> design/mta_pkg.sv
// ----------------------------------------------------------------------------
// mta_pkg: shared types and constants of the timestamped moving average
// Sizes, configuration register indexes, beat structs and the divider
// request/response structs.
// ----------------------------------------------------------------------------
package mta_pkg;

  localparam int MAX_WINDOW  = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int TIME_WIDTH  = 48;

  // Width of the window_length register as written by software.
  localparam int WL_W      = 9;
  // Width that holds an effective window length of 1 .. MAX_WINDOW.
  localparam int LEN_W     = $clog2(MAX_WINDOW + 1);
  // Width of a slot index into the ring.
  localparam int PTR_W     = $clog2(MAX_WINDOW);
  // Running sum of up to MAX_WINDOW signed values.
  localparam int SUM_W     = VALUE_WIDTH + $clog2(MAX_WINDOW);
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);
  localparam int ENTRY_W   = TIME_WIDTH + VALUE_WIDTH;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_TIME   = CFG_IDX_W'(1);

  typedef struct packed {
    logic        [TIME_WIDTH-1:0]  sample_time;
    logic signed [VALUE_WIDTH-1:0] sample_value;
  } in_beat_t;

  typedef struct packed {
    logic        [TIME_WIDTH-1:0]  out_time;
    logic signed [VALUE_WIDTH-1:0] out_mean;
  } out_beat_t;

  typedef struct packed {
    logic             start;
    logic             negate;
    logic [SUM_W-1:0] magnitude;
    logic [LEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
  } div_rsp_t;

endpackage

>>> design/mta_ram.sv
// ----------------------------------------------------------------------------
// mta_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module mta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/mta_div.sv
// ----------------------------------------------------------------------------
// mta_div: serial restoring divider
// Divides a sum magnitude by the window length, one quotient bit per cycle,
// and applies the sign at the end so the result truncates toward zero.
// ----------------------------------------------------------------------------
module mta_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mta_pkg::div_req_t req,
  output mta_pkg::div_rsp_t rsp
);

  logic [mta_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          done_r, done_nxt;
  logic [mta_pkg::SUM_W-1:0]     quot_r, quot_nxt;
  logic [mta_pkg::LEN_W-1:0]     rem_r, rem_nxt;
  logic [mta_pkg::LEN_W-1:0]     divisor_r, divisor_nxt;
  logic                          neg_r, neg_nxt;
  logic [mta_pkg::LEN_W:0]       trial;
  logic                          fits;
  logic [mta_pkg::SUM_W-1:0]     signed_quot;

  // The partial remainder with the next dividend bit brought in.
  assign trial = {rem_r, quot_r[mta_pkg::SUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor_r});

  always_comb begin
    cnt_nxt     = cnt_r;
    done_nxt    = done_r;
    quot_nxt    = quot_r;
    rem_nxt     = rem_r;
    divisor_nxt = divisor_r;
    neg_nxt     = neg_r;
    if (req.start) begin
      cnt_nxt     = mta_pkg::DIV_CNT_W'(mta_pkg::SUM_W);
      done_nxt    = 1'b0;
      quot_nxt    = req.magnitude;
      rem_nxt     = '0;
      divisor_nxt = req.divisor;
      neg_nxt     = req.negate;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - mta_pkg::DIV_CNT_W'(1);
      quot_nxt = {quot_r[mta_pkg::SUM_W-2:0], fits};
      rem_nxt  = fits ? mta_pkg::LEN_W'(trial - {1'b0, divisor_r})
                      : mta_pkg::LEN_W'(trial);
      if (cnt_r == mta_pkg::DIV_CNT_W'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r    <= quot_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
    neg_r     <= neg_nxt;
  end

  assign signed_quot  = neg_r ? (~quot_r + mta_pkg::SUM_W'(1)) : quot_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = signed_quot[mta_pkg::VALUE_WIDTH-1:0];

`ifndef SYNTHESIS
  // While the divider iterates it never reports a result.
  a_busy_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> !done_r)
    else $error("divider reports done while still iterating");

  // A start always leads into a full run of iterations.
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> (cnt_r == mta_pkg::DIV_CNT_W'(mta_pkg::SUM_W)) && !done_r)
    else $error("divider did not begin a run after start");

  // The remainder stays below the divisor between steps.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r != mta_pkg::DIV_CNT_W'(mta_pkg::SUM_W)) |-> rem_r < divisor_r)
    else $error("divider remainder out of range");
`endif

endmodule

>>> design/moving_average_timestamped.sv
// ----------------------------------------------------------------------------
// moving_average_timestamped: windowed mean of timestamped Q16.16 samples
// Each input beat carries a timestamp and a signed Q16.16 value; each one
// produces exactly one output beat with the mean of the last window_length
// samples (truncated toward zero) and either the sample's own timestamp or,
// with center_time set, the floor of the mean of the newest and oldest
// timestamps in the window. The first sample after reset, or after the
// effective window length changes, stands for a full window of its own
// value. A window_length of 0 acts as 1 and lengths above 256 act as 256.
// The block handles one sample at a time and accepts the next one once
// the output beat of the last is registered. The serial divider produces
// one bit of the 40-bit quotient per cycle. A finished beat waits in the
// output register, so a stalled output only holds the block once the
// following result is ready. The ring needs no clearing pass after reset.
// Configuration writes are taken at any time and must only be issued
// while no sample is in flight.
// ----------------------------------------------------------------------------
module moving_average_timestamped (
  input  logic                             clk,
  input  logic                             rst_n,
  // Sample input channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  mta_pkg::in_beat_t                in_beat,
  // Result output channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output mta_pkg::out_beat_t               out_beat,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mta_pkg::WL_W-1:0]         cfg_data
);

  // Sequencer states. The ring read of the slot being replaced happens on
  // the acceptance edge, the update and the read of the oldest slot in
  // S_RD, the output time in S_TIME, and the division runs in S_DIV.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_TIME = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [1:0]                          state_r, state_nxt;
  logic [mta_pkg::WL_W-1:0]            wl_r, wl_nxt;
  logic                                center_r, center_nxt;
  logic [mta_pkg::LEN_W-1:0]           active_len_r, active_len_nxt;
  logic signed [mta_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [mta_pkg::PTR_W-1:0]           ptr_r, ptr_nxt;
  logic [mta_pkg::LEN_W-1:0]           cnt_r, cnt_nxt;
  logic                                primed_r, primed_nxt;
  logic [mta_pkg::TIME_WIDTH-1:0]      fill_time_r, fill_time_nxt;
  logic signed [mta_pkg::VALUE_WIDTH-1:0] fill_value_r, fill_value_nxt;
  logic                                out_valid_r, out_valid_nxt;

  // Payload registers of the sample in flight and of the output beat.
  logic [mta_pkg::TIME_WIDTH-1:0]      t_r, t_nxt;
  logic signed [mta_pkg::VALUE_WIDTH-1:0] v_r, v_nxt;
  logic [mta_pkg::LEN_W-1:0]           len_r, len_nxt;
  logic                                fill_r, fill_nxt;
  logic [mta_pkg::TIME_WIDTH-1:0]      ot_r, ot_nxt;
  mta_pkg::out_beat_t                  out_beat_r, out_beat_nxt;

  logic                                in_acc;
  logic                                out_free;
  logic [mta_pkg::LEN_W-1:0]           len_eff;
  logic                                need_fill;
  logic [mta_pkg::LEN_W-1:0]           ptr_ext;
  logic [mta_pkg::LEN_W-1:0]           ptr_inc;
  logic [mta_pkg::PTR_W-1:0]           oldest;
  logic                                ram_we;
  logic [mta_pkg::PTR_W-1:0]           ram_raddr;
  logic [mta_pkg::ENTRY_W-1:0]         ram_wdata;
  logic [mta_pkg::ENTRY_W-1:0]         ram_rdata;
  logic [mta_pkg::TIME_WIDTH-1:0]      rd_time;
  logic signed [mta_pkg::VALUE_WIDTH-1:0] rd_value;
  logic signed [mta_pkg::VALUE_WIDTH-1:0] old_value;
  logic [mta_pkg::TIME_WIDTH-1:0]      far_time;
  logic [mta_pkg::TIME_WIDTH-1:0]      mid_time;
  mta_pkg::div_req_t                   div_req;
  mta_pkg::div_rsp_t                   div_rsp;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;
  assign cfg_ready = 1'b1;
  // The output register can take a new beat when empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;

  // Effective window length: zero acts as one, long windows saturate.
  always_comb begin
    if (wl_r == '0) begin
      len_eff = mta_pkg::LEN_W'(1);
    end else if (32'(wl_r) > mta_pkg::MAX_WINDOW) begin
      len_eff = mta_pkg::LEN_W'(mta_pkg::MAX_WINDOW);
    end else begin
      len_eff = mta_pkg::LEN_W'(wl_r);
    end
  end

  assign need_fill = !primed_r || (len_eff != active_len_r);

  // The slot after the one being replaced holds the oldest sample.
  assign ptr_ext = mta_pkg::LEN_W'(ptr_r);
  assign ptr_inc = ptr_ext + mta_pkg::LEN_W'(1);
  assign oldest  = (ptr_inc == len_r) ? '0 : mta_pkg::PTR_W'(ptr_inc);

  // Ring entries. A slot counts as written since the last refill when its
  // index is below cnt_r, because slots are written in order from zero;
  // any other slot still stands for the refill sample.
  assign rd_time   = ram_rdata[mta_pkg::ENTRY_W-1:mta_pkg::VALUE_WIDTH];
  assign rd_value  = ram_rdata[mta_pkg::VALUE_WIDTH-1:0];
  assign old_value = (ptr_ext < cnt_r) ? rd_value : fill_value_r;
  assign ram_we    = (state_r == S_RD);
  assign ram_wdata = {t_r, v_r};
  assign ram_raddr = (state_r == S_RD) ? oldest : ptr_r;

  mta_ram #(
    .WIDTH (mta_pkg::ENTRY_W),
    .DEPTH (mta_pkg::MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Oldest timestamp for the centered time. After a refill, and for a
  // window of one, newest and oldest are both the current sample. In
  // S_TIME ptr_r already points at the oldest slot.
  always_comb begin
    if (fill_r || (len_r == mta_pkg::LEN_W'(1))) begin
      far_time = t_r;
    end else if (ptr_ext < cnt_r) begin
      far_time = rd_time;
    end else begin
      far_time = fill_time_r;
    end
  end

  // Floor of the mean of two timestamps without overflow.
  assign mid_time = (t_r >> 1) + (far_time >> 1)
                  + mta_pkg::TIME_WIDTH'(t_r[0] & far_time[0]);

  assign div_req.start     = (state_r == S_TIME);
  assign div_req.negate    = sum_r[mta_pkg::SUM_W-1];
  assign div_req.magnitude = sum_r[mta_pkg::SUM_W-1] ? mta_pkg::SUM_W'(-sum_r)
                                                     : mta_pkg::SUM_W'(sum_r);
  assign div_req.divisor   = len_r;

  mta_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt      = state_r;
    wl_nxt         = wl_r;
    center_nxt     = center_r;
    active_len_nxt = active_len_r;
    sum_nxt        = sum_r;
    ptr_nxt        = ptr_r;
    cnt_nxt        = cnt_r;
    primed_nxt     = primed_r;
    fill_time_nxt  = fill_time_r;
    fill_value_nxt = fill_value_r;
    out_valid_nxt  = out_valid_r;
    t_nxt          = t_r;
    v_nxt          = v_r;
    len_nxt        = len_r;
    fill_nxt       = fill_r;
    ot_nxt         = ot_r;
    out_beat_nxt   = out_beat_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mta_pkg::CFG_WINDOW_LENGTH: wl_nxt     = cfg_data;
        mta_pkg::CFG_CENTER_TIME:   center_nxt = cfg_data[0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          t_nxt    = in_beat.sample_time;
          v_nxt    = in_beat.sample_value;
          len_nxt  = len_eff;
          fill_nxt = need_fill;
          if (need_fill) begin
            // Refill: the whole window takes the value of this sample. Both
            // factors are widened to the sum width so the product is exact.
            sum_nxt        = mta_pkg::SUM_W'($signed({1'b0, len_eff}))
                             * mta_pkg::SUM_W'(in_beat.sample_value);
            ptr_nxt        = '0;
            cnt_nxt        = '0;
            primed_nxt     = 1'b1;
            fill_time_nxt  = in_beat.sample_time;
            fill_value_nxt = in_beat.sample_value;
            active_len_nxt = len_eff;
            state_nxt      = S_TIME;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        // The slot being replaced was read on the acceptance edge.
        sum_nxt   = sum_r + mta_pkg::SUM_W'(v_r) - mta_pkg::SUM_W'(old_value);
        cnt_nxt   = (ptr_inc > cnt_r) ? ptr_inc : cnt_r;
        ptr_nxt   = oldest;
        state_nxt = S_TIME;
      end
      S_TIME: begin
        ot_nxt    = center_r ? mid_time : t_r;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done && out_free) begin
          out_beat_nxt.out_time = ot_r;
          out_beat_nxt.out_mean = div_rsp.quotient;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wl_r         <= mta_pkg::WL_W'(1);
      center_r     <= 1'b0;
      active_len_r <= '0;
      sum_r        <= '0;
      ptr_r        <= '0;
      cnt_r        <= '0;
      primed_r     <= 1'b0;
      fill_time_r  <= '0;
      fill_value_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wl_r         <= wl_nxt;
      center_r     <= center_nxt;
      active_len_r <= active_len_nxt;
      sum_r        <= sum_nxt;
      ptr_r        <= ptr_nxt;
      cnt_r        <= cnt_nxt;
      primed_r     <= primed_nxt;
      fill_time_r  <= fill_time_nxt;
      fill_value_r <= fill_value_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    v_r        <= v_nxt;
    len_r      <= len_nxt;
    fill_r     <= fill_nxt;
    ot_r       <= ot_nxt;
    out_beat_r <= out_beat_nxt;
  end

`ifndef SYNTHESIS
  // An accepted sample keeps the input side stalled on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input accepted while a sample is still in flight");

  // The count of slots written since the refill never exceeds the window.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= active_len_r)
    else $error("written-slot count exceeds the window length");

  // The ring pointer stays inside the active window.
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    primed_r |-> (mta_pkg::LEN_W'(ptr_r) < active_len_r))
    else $error("ring pointer outside the active window");

  // A finished division with room at the output yields an output beat
  // and frees the input side.
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && div_rsp.done && out_free |=> out_valid_r && !in_stall)
    else $error("finished result was not delivered to the output");
`endif

endmodule

>>> dv/moving_average_timestamped_tb.sv
// ----------------------------------------------------------------------------
// moving_average_timestamped_tb: self-checking bench for the windowed mean
// Streams timestamped Q16.16 samples through the block under a series of
// window lengths and time modes. It keeps a behavioral copy of the sample
// ring and running sum, predicts every output beat, and compares each
// accepted beat field by field. The sample side idles in random bursts and
// the result side stalls on its own random pattern.
// ----------------------------------------------------------------------------
module moving_average_timestamped_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // How many random samples to send after the directed part.
  localparam int RANDOM_ITEMS = 1800;

  localparam logic signed [mta_pkg::VALUE_WIDTH-1:0] VAL_MAX =
    {1'b0, {(mta_pkg::VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [mta_pkg::VALUE_WIDTH-1:0] VAL_MIN =
    {1'b1, {(mta_pkg::VALUE_WIDTH-1){1'b0}}};
  localparam logic [mta_pkg::TIME_WIDTH-1:0]         TIME_MAX = '1;

  // Register indexes past the last defined register; writes there must be ignored.
  localparam logic [mta_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LOW = mta_pkg::CFG_CENTER_TIME + 1'b1;
  localparam logic [mta_pkg::CFG_IDX_W-1:0] CFG_UNUSED_TOP = '1;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  mta_pkg::in_beat_t             in_beat   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  mta_pkg::out_beat_t            out_beat;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [mta_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mta_pkg::WL_W-1:0]      cfg_data  = '0;

  moving_average_timestamped dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioral window. The ring holds one (time, value) pair per slot; only
  // the first span slots are in use. next_slot is the oldest entry, which is
  // the next one to be overwritten.
  // --------------------------------------------------------------------------
  logic [mta_pkg::WL_W-1:0]               shadow_window_length = mta_pkg::WL_W'(1);
  logic                                   shadow_center        = 1'b0;
  logic [mta_pkg::TIME_WIDTH-1:0]         ring_time  [mta_pkg::MAX_WINDOW];
  logic signed [mta_pkg::VALUE_WIDTH-1:0] ring_value [mta_pkg::MAX_WINDOW];
  logic signed [mta_pkg::SUM_W-1:0]       window_sum  = '0;
  int                                     next_slot   = 0;
  logic                                   ring_loaded = 1'b0;
  logic [mta_pkg::LEN_W-1:0]              loaded_span = '0;

  mta_pkg::in_beat_t  sample_backlog[$];
  mta_pkg::out_beat_t predicted_averages[$];
  mta_pkg::out_beat_t want;
  int                 mismatch_count = 0;

  // Sender burst/gap counters and receiver stall pattern.
  int   burst_left  = 0;
  int   gap_left    = 0;
  int   stall_left  = 0;
  logic stall_level = 1'b0;

  logic [mta_pkg::TIME_WIDTH-1:0] clock_cursor = '0;

  // A window length of zero behaves as one; anything past the ring size
  // saturates to the ring size.
  function automatic logic [mta_pkg::LEN_W-1:0] span_of(input logic [mta_pkg::WL_W-1:0] wl);
    if (wl == '0) return mta_pkg::LEN_W'(1);
    if (wl > mta_pkg::MAX_WINDOW) return mta_pkg::LEN_W'(mta_pkg::MAX_WINDOW);
    return mta_pkg::LEN_W'(wl);
  endfunction

  // Takes one accepted sample into the window and returns the output beat it
  // must produce.
  function automatic mta_pkg::out_beat_t advance_window(input mta_pkg::in_beat_t s);
    logic [mta_pkg::LEN_W-1:0]    span;
    int                           newest;
    int                           oldest;
    logic [mta_pkg::TIME_WIDTH:0] time_pair;
    mta_pkg::out_beat_t           r;
    span = span_of(shadow_window_length);
    if (!ring_loaded || span != loaded_span) begin
      // First sample after reset or after the effective length moved: it
      // stands for the whole window.
      for (int k = 0; k < span; k++) begin
        ring_time[k]  = s.sample_time;
        ring_value[k] = s.sample_value;
      end
      window_sum  = s.sample_value * $signed({1'b0, span});
      next_slot   = 0;
      ring_loaded = 1'b1;
      loaded_span = span;
      newest      = span - 1;
      oldest      = 0;
    end else begin
      newest = next_slot;
      window_sum = window_sum + s.sample_value - ring_value[newest];
      ring_time[newest]  = s.sample_time;
      ring_value[newest] = s.sample_value;
      oldest    = (newest + 1 == span) ? 0 : newest + 1;
      next_slot = oldest;
    end
    if (shadow_center) begin
      // Floor of the midpoint, taken one bit wider so nothing is lost.
      time_pair  = {1'b0, ring_time[newest]} + {1'b0, ring_time[oldest]};
      r.out_time = time_pair[mta_pkg::TIME_WIDTH:1];
    end else begin
      r.out_time = s.sample_time;
    end
    // Signed division truncates toward zero, as the block does.
    r.out_mean = mta_pkg::VALUE_WIDTH'(longint'(window_sum) / longint'(span));
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Sample driver. A beat is taken into the window model at the edge where
  // it is accepted. The sender alternates between bursts of back-to-back
  // beats and random gaps; the gap counter only runs while nothing is
  // offered, so gaps land anywhere in the block's divide sequence.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        predicted_averages.insert(predicted_averages.size(), advance_window(in_beat));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || sample_backlog.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_beat  <= sample_backlog.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Every accepted output beat is matched against the oldest
  // prediction. The stall pattern holds each level for a random run: short
  // stall runs, longer stretches with the output free.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_averages.size() == 0) begin
          flag_mismatch("output beat with no sample outstanding");
        end else begin
          want = predicted_averages.pop_front();
          if (out_beat.out_time !== want.out_time)
            flag_mismatch($sformatf("out_time got %0h, expected %0h",
                                    out_beat.out_time, want.out_time));
          if (out_beat.out_mean !== want.out_mean)
            flag_mismatch($sformatf("out_mean got %0d, expected %0d",
                                    out_beat.out_mean, want.out_mean));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else begin
        stall_level = ($urandom_range(0, 2) == 0);
        stall_left  = stall_level ? $urandom_range(0, 40) : $urandom_range(0, 150);
      end
      out_stall <= stall_level;
    end
  end

  // One register write; the shadow copy changes at the handshake edge.
  task automatic write_reg(input logic [mta_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mta_pkg::WL_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == mta_pkg::CFG_WINDOW_LENGTH) shadow_window_length = data;
    else if (idx == mta_pkg::CFG_CENTER_TIME) shadow_center = data[0];
    cfg_valid <= 1'b0;
  endtask

  // Block until the backlog is sent and every predicted beat has come back.
  // The check runs on the falling edge, after the driver and the monitor
  // have settled, so a beat being picked up at the rising edge is seen.
  // The block works on one sample at a time, so it is idle from then on.
  task automatic settle();
    while (sample_backlog.size() != 0 || in_valid || predicted_averages.size() != 0)
      @(negedge clk);
  endtask

  function automatic mta_pkg::in_beat_t beat(input logic [mta_pkg::TIME_WIDTH-1:0] t,
                                             input logic signed [mta_pkg::VALUE_WIDTH-1:0] v);
    mta_pkg::in_beat_t b;
    b.sample_time  = t;
    b.sample_value = v;
    return b;
  endfunction

  function automatic logic signed [mta_pkg::VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2, 3:    return mta_pkg::VALUE_WIDTH'($signed($urandom_range(0, 2000)) - 1000);
      default: return mta_pkg::VALUE_WIDTH'($urandom);
    endcase
  endfunction

  // Appends one sample to the backlog the driver draws from.
  task automatic add_sample(input mta_pkg::in_beat_t b);
    sample_backlog.insert(sample_backlog.size(), b);
  endtask

  // Timestamps mostly climb in random steps, with the odd repeat and the odd
  // jump to an arbitrary point of the full range.
  task automatic queue_samples(input int count);
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 15))
        0:       clock_cursor = mta_pkg::TIME_WIDTH'({$urandom, $urandom});
        1:       ;
        default: clock_cursor = clock_cursor + $urandom_range(1, 5000);
      endcase
      add_sample(beat(clock_cursor, pick_value()));
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus sequence.
  // --------------------------------------------------------------------------
  int window_extremes[7] = '{0, 1, 2, 255, 256, 257, 511};
  int random_sent = 0;
  int span_now;
  int count;

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset window of one: every beat is its own mean, extremes of both fields.
    add_sample(beat('0, '0));
    add_sample(beat(TIME_MAX, VAL_MAX));
    add_sample(beat(TIME_MAX, VAL_MIN));
    add_sample(beat(mta_pkg::TIME_WIDTH'(1), -1));
    settle();

    // Window of four, centred time. The second beat gives a negative sum
    // that must truncate toward zero, and an odd timestamp pair whose
    // midpoint rounds down. The top timestamps check the midpoint carry.
    write_reg(mta_pkg::CFG_WINDOW_LENGTH, mta_pkg::WL_W'(4));
    write_reg(mta_pkg::CFG_CENTER_TIME, mta_pkg::WL_W'(1));
    add_sample(beat(mta_pkg::TIME_WIDTH'(101), -7));
    add_sample(beat(mta_pkg::TIME_WIDTH'(102), 2));
    add_sample(beat(TIME_MAX, VAL_MAX));
    add_sample(beat(TIME_MAX - 1'b1, VAL_MIN));
    add_sample(beat(TIME_MAX, VAL_MIN));
    add_sample(beat(mta_pkg::TIME_WIDTH'(7), -1));
    settle();

    // Length zero acts as one, which is a change and forces a refill. Only
    // bit zero of the time-mode write counts.
    write_reg(mta_pkg::CFG_WINDOW_LENGTH, '0);
    write_reg(mta_pkg::CFG_CENTER_TIME, mta_pkg::WL_W'(9'h1FE));
    add_sample(beat(mta_pkg::TIME_WIDTH'(5), 3));
    add_sample(beat(mta_pkg::TIME_WIDTH'(6), -3));
    settle();

    // Oversized length saturates to the full ring. Moving between lengths
    // that saturate to the same span must not refill.
    write_reg(mta_pkg::CFG_WINDOW_LENGTH, '1);
    write_reg(mta_pkg::CFG_CENTER_TIME, mta_pkg::WL_W'(1));
    add_sample(beat(mta_pkg::TIME_WIDTH'(1000), VAL_MAX));
    add_sample(beat(mta_pkg::TIME_WIDTH'(2000), VAL_MIN));
    add_sample(beat(mta_pkg::TIME_WIDTH'(3000), VAL_MAX));
    settle();
    write_reg(mta_pkg::CFG_WINDOW_LENGTH, mta_pkg::WL_W'(mta_pkg::MAX_WINDOW));
    add_sample(beat(mta_pkg::TIME_WIDTH'(4000), -5));
    add_sample(beat(mta_pkg::TIME_WIDTH'(5000), 11));
    settle();
    write_reg(mta_pkg::CFG_WINDOW_LENGTH, mta_pkg::WL_W'(mta_pkg::MAX_WINDOW + 1));
    add_sample(beat(mta_pkg::TIME_WIDTH'(6000), 1));
    settle();

    // Writes to undefined indexes leave both registers alone.
    write_reg(CFG_UNUSED_LOW, '1);
    write_reg(CFG_UNUSED_TOP, '0);
    add_sample(beat(mta_pkg::TIME_WIDTH'(7000), 2));
    settle();

    // Random phases. Each one picks a setting, then sends enough samples to
    // wrap the ring at least once (capped for the largest windows and by
    // what is left of the sample budget).
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0, 1, 2: write_reg(mta_pkg::CFG_WINDOW_LENGTH, mta_pkg::WL_W'($urandom_range(1, 16)));
        3:       write_reg(mta_pkg::CFG_WINDOW_LENGTH, mta_pkg::WL_W'($urandom));
        4:       write_reg(mta_pkg::CFG_WINDOW_LENGTH,
                           mta_pkg::WL_W'(window_extremes[$urandom_range(0, 6)]));
        default: ;
      endcase
      if ($urandom_range(0, 1) == 0)
        write_reg(mta_pkg::CFG_CENTER_TIME, mta_pkg::WL_W'($urandom));
      if ($urandom_range(0, 7) == 0)
        write_reg(mta_pkg::CFG_IDX_W'($urandom_range(CFG_UNUSED_LOW, CFG_UNUSED_TOP)),
                  mta_pkg::WL_W'($urandom));
      span_now = span_of(shadow_window_length);
      count = span_now + $urandom_range(1, span_now + 20);
      if (count > 400) count = 400;
      if (count > RANDOM_ITEMS - random_sent) count = RANDOM_ITEMS - random_sent;
      if ($urandom_range(0, 3) == 0) begin
        // Hold the sender mid-phase until the block has drained completely.
        queue_samples(count / 2);
        settle();
        queue_samples(count - count / 2);
      end else begin
        queue_samples(count);
      end
      settle();
      random_sent += count;
    end

    // Give any stray beat time to show up before the verdict.
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && predicted_averages.size() == 0) begin
      $display("** moving_average_timestamped: PASSED **");
    end else begin
      $display("** moving_average_timestamped: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #20_000_000;
    $display("** moving_average_timestamped: FAILED **");
    $finish;
  end

endmodule

>>> files.f
design/mta_pkg.sv
design/mta_ram.sv
design/mta_div.sv
design/moving_average_timestamped.sv
dv/moving_average_timestamped_tb.sv
